/* design/bced_pkg.sv */
package bced_pkg;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_UP     = 3'd2;
  localparam logic [2:0] EV_SINGLE = 3'd3;
  localparam logic [2:0] EV_DOUBLE = 3'd4;
  localparam logic [2:0] EV_REPEAT = 3'd5;
  localparam logic [2:0] EV_LSTART = 3'd6;
  localparam logic [2:0] EV_LHOLD  = 3'd7;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HELD  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_AGAIN = 3'd3;
  localparam logic [2:0] ST_LONG  = 3'd5;

  localparam logic [1:0] REG_KEY_MASK  = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] REG_SHORT     = 2'd2;
  localparam logic [1:0] REG_LONG      = 2'd3;

  localparam int unsigned MaxEvents = 3;

  typedef struct packed {
    logic [7:0]  key_mask;
    logic [3:0]  bounce_lim;
    logic [15:0] short_lim;
    logic [15:0] long_lim;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  machine_state;
    logic [15:0] tick_count;
    logic [3:0]  debounce_count;
    logic        stable_level;
    logic [7:0]  press_tally;
    logic [2:0]  latched_event;
  } state_t;

  typedef struct packed {
    logic [MaxEvents-1:0][2:0] ev;
    logic [1:0]                num;
  } evlist_t;

endpackage

/* design/bced_step.sv */
module bced_step (
  input  bced_pkg::cfg_t    cfg_i,
  input  bced_pkg::state_t  state_i,
  input  logic [7:0]        port_sample_i,
  output bced_pkg::state_t  state_o,
  output bced_pkg::evlist_t events_o
);
  import bced_pkg::*;

  logic        raw;
  logic [15:0] tick1;
  logic [3:0]  dc1;
  logic        stable1;
  logic [3:0]  dc_next;
  logic [2:0]  ev0, ev1, ev2;
  logic [1:0]  n;
  logic [2:0]  latched;

  assign raw = |(port_sample_i & cfg_i.key_mask);
  assign tick1 = (state_i.machine_state != ST_IDLE && state_i.tick_count != 16'hFFFF) ?
                 state_i.tick_count + 16'd1 : state_i.tick_count;
  assign dc1 = state_i.debounce_count + 4'd1;

  // debounce
  always_comb begin
    stable1 = state_i.stable_level;
    dc_next = 4'd0;
    if (raw != state_i.stable_level) begin
      if (dc1 >= cfg_i.bounce_lim) begin
        stable1 = raw;
      end else begin
        dc_next = dc1;
      end
    end
  end

  always_comb begin
    state_o = state_i;
    state_o.tick_count = tick1;
    state_o.debounce_count = dc_next;
    state_o.stable_level = stable1;
    ev0 = EV_NONE;
    ev1 = EV_NONE;
    ev2 = EV_NONE;
    n = 2'd0;
    latched = state_i.latched_event;
    case (state_i.machine_state)
      ST_IDLE: begin
        if (stable1) begin
          ev0 = EV_DOWN;
          n = 2'd1;
          state_o.tick_count = 16'd0;
          state_o.press_tally = 8'd1;
          state_o.machine_state = ST_HELD;
        end else begin
          latched = EV_NONE;
        end
      end
      ST_HELD: begin
        if (!stable1) begin
          ev0 = EV_UP;
          n = 2'd1;
          state_o.tick_count = 16'd0;
          state_o.machine_state = ST_WAIT;
        end else if (tick1 > cfg_i.long_lim) begin
          ev0 = EV_LSTART;
          n = 2'd1;
          state_o.machine_state = ST_LONG;
        end
      end
      ST_WAIT: begin
        if (stable1) begin
          ev0 = EV_DOWN;
          n = 2'd1;
          if (state_i.press_tally != 8'hFF) begin
            state_o.press_tally = state_i.press_tally + 8'd1;
          end
          state_o.tick_count = 16'd0;
          state_o.machine_state = ST_AGAIN;
        end else if (tick1 > cfg_i.short_lim) begin
          state_o.machine_state = ST_IDLE;
          if (state_i.press_tally == 8'd1) begin
            ev0 = EV_SINGLE;
            n = 2'd1;
          end else if (state_i.press_tally == 8'd2) begin
            ev0 = EV_DOUBLE;
            ev1 = EV_REPEAT;
            n = 2'd2;
          end else if (state_i.press_tally > 8'd2) begin
            ev0 = EV_REPEAT;
            n = 2'd1;
          end
        end
      end
      ST_AGAIN: begin
        if (!stable1) begin
          ev0 = EV_UP;
          n = 2'd1;
          if (tick1 < cfg_i.short_lim) begin
            state_o.tick_count = 16'd0;
            state_o.machine_state = ST_WAIT;
          end else begin
            state_o.machine_state = ST_IDLE;
            if (state_i.press_tally == 8'd2) begin
              ev1 = EV_DOUBLE;
              ev2 = EV_REPEAT;
              n = 2'd3;
            end else if (state_i.press_tally > 8'd2) begin
              ev1 = EV_REPEAT;
              n = 2'd2;
            end
          end
        end
      end
      ST_LONG: begin
        n = 2'd1;
        if (stable1) begin
          ev0 = EV_LHOLD;
        end else begin
          ev0 = EV_UP;
          state_o.machine_state = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    case (n)
      2'd1:    latched = ev0;
      2'd2:    latched = ev1;
      2'd3:    latched = ev2;
      default: begin
      end
    endcase
    state_o.latched_event = latched;

    events_o.ev[0] = ev0;
    events_o.ev[1] = ev1;
    events_o.ev[2] = ev2;
    events_o.num = (n == 2'd0) ? 2'd1 : n;
  end

endmodule

/* design/button_click_event_detector.sv */
// Button click event detector.
// Input channel: one word per periodic tick (port_sample_i), with in_valid_i
// and in_stall_o. Output channel: one to three words per tick (event_code_o,
// held_event_o, press_count_o, last_of_tick_o), with out_valid_o and
// out_stall_i; last_of_tick_o marks the final word of a tick.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, write only while the block is idle.
// An accepted tick waits in the input register until the result buffer is free.
// A tick occupies the output buffer until its last word is taken, of one to
// three words; the input register takes the next tick meanwhile,
// and it is loaded in the cycle the last word of the previous tick leaves.
// Stall on the output holds the current word and backs up into in_stall_o.
// Reset restores the register defaults (mask 1, debounce 3, short 60,
// long 200), idle state, released level and clears both channels.
module button_click_event_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  port_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_code_o,
  output logic [2:0]  held_event_o,
  output logic [7:0]  press_count_o,
  output logic        last_of_tick_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bced_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  evlist_t events;

  logic       in_valid_q;
  logic [7:0] sample_q;

  logic                      out_valid_q;
  logic [MaxEvents-1:0][2:0] ev_q;
  logic [1:0]                num_q;
  logic [1:0]                idx_q;
  logic [2:0]                held_q;
  logic [7:0]                press_q;

  logic is_last, take, buf_free, load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_mask   <= 8'd1;
      cfg_q.bounce_lim <= 4'd3;
      cfg_q.short_lim  <= 16'd60;
      cfg_q.long_lim   <= 16'd200;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY_MASK: cfg_q.key_mask   <= cfg_data_i[7:0];
        REG_DEBOUNCE: cfg_q.bounce_lim <= cfg_data_i[3:0];
        REG_SHORT:    cfg_q.short_lim  <= cfg_data_i;
        REG_LONG:     cfg_q.long_lim   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign is_last  = (idx_q == num_q - 2'd1);
  assign take     = out_valid_q && !out_stall_i;
  assign buf_free = !out_valid_q || (take && is_last);
  assign load     = in_valid_q && buf_free;

  assign in_stall_o = in_valid_q && !buf_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= port_sample_i;
    end
  end

  bced_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .port_sample_i (sample_q),
    .state_o       (state_d),
    .events_o      (events)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.machine_state  <= ST_IDLE;
      state_q.tick_count     <= 16'd0;
      state_q.debounce_count <= 4'd0;
      state_q.stable_level   <= 1'b0;
      state_q.press_tally    <= 8'd0;
      state_q.latched_event  <= EV_NONE;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      num_q       <= 2'd1;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= 2'd0;
      num_q       <= events.num;
    end else if (take) begin
      if (is_last) begin
        out_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q    <= events.ev;
      held_q  <= state_d.latched_event;
      press_q <= state_d.press_tally;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_code_o   = ev_q[idx_q];
  assign held_event_o   = held_q;
  assign press_count_o  = press_q;
  assign last_of_tick_o = is_last;

`ifndef ASSERT_OFF
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (num_q != 2'd0 && idx_q < num_q))
    else $error("word index beyond the tick's word count");

  a_load_starts_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && idx_q == 2'd0))
    else $error("new tick did not start at its first word");

  a_hold_mid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !is_last && in_valid_q) |-> in_stall_o)
    else $error("input taken while a tick is still draining");

  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load |=> $stable(state_q))
    else $error("detector state changed without a tick");
`endif

endmodule
